@@ hw/rtl/akrt_pkg.sv @@
`default_nettype none

package akrt_pkg;

  // Width of a stored key position, in micrometres.
  localparam int POS_WIDTH = 16;
  // Signed compare width: two extra bits keep sums and differences from wrapping.
  localparam int CMP_WIDTH = POS_WIDTH + 2;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int OUT_DATA_WIDTH = 40;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic signed [CMP_WIDTH-1:0] cmp_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_TRIGGER_MODE        = 3'd0,
    REG_UPPER_DEADZONE      = 3'd1,
    REG_LOWER_DEADZONE      = 3'd2,
    REG_RELEASE_SENSITIVITY = 3'd3,
    REG_PRESS_SENSITIVITY   = 3'd4,
    REG_ACTUATION_DEPTH     = 3'd5,
    REG_TRAVEL_RANGE        = 3'd6
  } cfg_reg_t;

  localparam logic MODE_RAPID = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  localparam pos_t UPPER_DEADZONE_RESET      = POS_WIDTH'(200);
  localparam pos_t LOWER_DEADZONE_RESET      = POS_WIDTH'(200);
  localparam pos_t RELEASE_SENSITIVITY_RESET = POS_WIDTH'(100);
  localparam pos_t PRESS_SENSITIVITY_RESET   = POS_WIDTH'(100);
  localparam pos_t ACTUATION_DEPTH_RESET     = POS_WIDTH'(2000);
  localparam pos_t TRAVEL_RANGE_RESET        = POS_WIDTH'(4000);

  typedef struct packed {
    logic trigger_mode;
    pos_t upper_deadzone;
    pos_t lower_deadzone;
    pos_t release_sensitivity;
    pos_t press_sensitivity;
    pos_t actuation_depth;
    pos_t travel_range;
  } cfg_t;

  typedef struct packed {
    logic key_down;
    pos_t top_mark;
    pos_t bottom_mark;
  } result_t;

  function automatic cmp_t to_cmp(pos_t value);
    return cmp_t'({2'b00, value});
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/akrt_cfg.sv @@
`default_nettype none

module akrt_cfg
  import akrt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                            cfg
);

  pos_t wr_pos;

  assign wr_pos = cfg_data[POS_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_mode        <= MODE_RAPID;
      cfg.upper_deadzone      <= UPPER_DEADZONE_RESET;
      cfg.lower_deadzone      <= LOWER_DEADZONE_RESET;
      cfg.release_sensitivity <= RELEASE_SENSITIVITY_RESET;
      cfg.press_sensitivity   <= PRESS_SENSITIVITY_RESET;
      cfg.actuation_depth     <= ACTUATION_DEPTH_RESET;
      cfg.travel_range        <= TRAVEL_RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_MODE:        cfg.trigger_mode        <= cfg_data[0];
        REG_UPPER_DEADZONE:      cfg.upper_deadzone      <= wr_pos;
        REG_LOWER_DEADZONE:      cfg.lower_deadzone      <= wr_pos;
        REG_RELEASE_SENSITIVITY: cfg.release_sensitivity <= wr_pos;
        REG_PRESS_SENSITIVITY:   cfg.press_sensitivity   <= wr_pos;
        REG_ACTUATION_DEPTH:     cfg.actuation_depth     <= wr_pos;
        REG_TRAVEL_RANGE:        cfg.travel_range        <= wr_pos;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/akrt_tracker.sv @@
`default_nettype none

module akrt_tracker
  import akrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire pos_t sample,
  input  wire cfg_t cfg,
  output result_t   state
);

  result_t state_next;
  cmp_t    s_cmp;
  cmp_t    bottom_zone;
  cmp_t    release_point;
  cmp_t    press_point;

  assign s_cmp         = to_cmp(sample);
  assign bottom_zone   = to_cmp(cfg.travel_range) - to_cmp(cfg.lower_deadzone);
  assign release_point = to_cmp(state.bottom_mark) - to_cmp(cfg.release_sensitivity);
  assign press_point   = to_cmp(state.top_mark) + to_cmp(cfg.press_sensitivity);

  always_comb begin
    state_next = state;
    if (cfg.trigger_mode == MODE_FIXED) begin
      state_next.key_down    = sample >= cfg.actuation_depth;
      state_next.top_mark    = '0;
      state_next.bottom_mark = cfg.travel_range;
    end else if (sample <= cfg.upper_deadzone) begin
      // Upper deadzone wins over every other rapid-mode rule, even an overlapping lower zone.
      state_next.key_down    = 1'b0;
      state_next.top_mark    = (sample < state.top_mark) ? sample : state.top_mark;
      state_next.bottom_mark = '0;
    end else if (s_cmp >= bottom_zone) begin
      state_next.key_down    = 1'b1;
      state_next.top_mark    = cfg.travel_range;
      state_next.bottom_mark = (sample > state.bottom_mark) ? sample : state.bottom_mark;
    end else if (state.key_down) begin
      if (s_cmp <= release_point) begin
        state_next.key_down    = 1'b0;
        state_next.top_mark    = sample;
        state_next.bottom_mark = '0;
      end else begin
        state_next.bottom_mark = (sample > state.bottom_mark) ? sample : state.bottom_mark;
      end
    end else begin
      if (s_cmp >= press_point) begin
        state_next.key_down    = 1'b1;
        state_next.top_mark    = cfg.travel_range;
        state_next.bottom_mark = sample;
      end else begin
        state_next.top_mark = (sample < state.top_mark) ? sample : state.top_mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_upper_releases : assert property (@(posedge clk) disable iff (rst)
    step && cfg.trigger_mode == MODE_RAPID && sample <= cfg.upper_deadzone
      |=> !state.key_down && state.bottom_mark == '0)
    else $error("upper deadzone sample left key pressed");

  a_fixed_marks : assert property (@(posedge clk) disable iff (rst)
    step && cfg.trigger_mode == MODE_FIXED
      |=> state.top_mark == '0 && state.bottom_mark == $past(cfg.travel_range))
    else $error("fixed mode marks wrong");

  a_hold_when_idle : assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state))
    else $error("tracker state moved without a sample");

endmodule

`default_nettype wire

@@ hw/rtl/analog_key_rapid_trigger.sv @@
`default_nettype none

// Rapid-trigger analog key. Each input beat carries one key travel sample, the
// distance from the top of travel in micrometres, and produces exactly one
// output beat with the pressed flag and the tracked top and bottom marks after
// that sample. In rapid-trigger mode the key releases inside the upper deadzone,
// presses inside the lower deadzone, and between them presses after moving down
// by the press sensitivity from its highest point and releases after moving up
// by the release sensitivity from its lowest point. In fixed mode it is pressed
// at or past the actuation depth, and the marks read 0 and the travel range.
// The block takes one beat per cycle while the output side keeps up: a sample
// waits in the input register, the tracker updates its state registers from it
// in a single pass, and those registers present the output beat. A stalled
// output holds the sample in the input register; otherwise the tracker's state
// feedback loop lets a beat follow every cycle while the output side keeps up.
// Write configuration only while no beat is in flight.
module analog_key_rapid_trigger
  import akrt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration write port.
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  // Sample stream.
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [15:0]                s_tdata,  // [15:0] depth_sample
  // Result stream.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [0] key_down, [16:1] top_mark, [32:17] bottom_mark, [39:33] zero
  output logic [OUT_DATA_WIDTH-1:0]       m_tdata
);

  cfg_t    cfg;
  result_t state;
  logic    in_full;
  pos_t    in_sample;
  logic    advance;

  akrt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The tracker's state registers double as the result register: they only
  // change when a beat moves into the output slot.
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  akrt_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_sample),
    .cfg    (cfg),
    .state  (state)
  );

  assign m_tdata = {7'd0, state.bottom_mark, state.top_mark, state.key_down};

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    in_full && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are full");

  a_advance_shows_result : assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed sample produced no output beat");

  a_fixed_top_zero : assert property (@(posedge clk) disable iff (rst)
    advance && cfg.trigger_mode == MODE_FIXED |=> m_tdata[16:1] == '0)
    else $error("fixed mode top mark not zero");

endmodule

`default_nettype wire
